// ===== rtl/core/csu_pkg.sv =====
// Shared types, character constants and character-class functions for the literal decoder.
`default_nettype none

package csu_pkg;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;

    // result buffer entries; pointers wrap by truncation, so keep a power of two
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic       status;
    } res_t;

    typedef struct packed {
        logic push0;
        logic push1;
        res_t res0;
        res_t res1;
    } push_t;

    // {hit, value} for a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // {hit, byte} for a single-letter escape
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3F:   r = {1'b1, 8'h3F};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csu_decode.sv =====
// Escape-sequence state machine: turns one consumed byte into up to two results.
`default_nettype none

module csu_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           consume,
    input  wire logic [7:0]     ch,
    input  wire logic           fin,
    output csu_pkg::push_t      push
);

    localparam logic [2:0] PH_OPEN = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] val_reg, val_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       failed_reg, failed_next;

    logic [4:0]      hx;
    logic [8:0]      se;
    logic            is_oct;
    logic [8:0]      oct_v;
    logic            emit_a;
    logic [7:0]      byte_a;
    logic            emit_b;
    logic            body_path;
    csu_pkg::res_t   res_a, res_b, res_e;

    always_comb
    begin
        hx     = csu_pkg::hex_digit(ch);
        se     = csu_pkg::simple_esc(ch);
        is_oct = ch inside {[csu_pkg::CH_ZERO:csu_pkg::CH_SEVEN]};
        oct_v  = {val_reg[5:0], ch[2:0]};

        phase_next  = phase_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        emit_a      = 1'b0;
        byte_a      = val_reg;
        emit_b      = 1'b0;
        body_path   = 1'b0;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    if (fin || ch != csu_pkg::CH_QUOTE)
                    begin
                        failed_next = 1'b1;
                    end
                    phase_next = PH_BODY;
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    if (fin)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (se[8])
                    begin
                        emit_a = 1'b1;
                        byte_a = se[7:0];
                    end
                    else if (ch == csu_pkg::CH_X)
                    begin
                        val_next   = 8'd0;
                        cnt_next   = 2'd0;
                        phase_next = PH_HEX;
                    end
                    else if (is_oct)
                    begin
                        val_next   = {5'd0, ch[2:0]};
                        cnt_next   = 2'd1;
                        phase_next = PH_OCT;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    if (!fin && hx[4])
                    begin
                        if (val_reg[7:4] != 4'd0)
                        begin
                            failed_next = 1'b1;
                            phase_next  = PH_BODY;
                        end
                        else
                        begin
                            val_next = {val_reg[3:0], hx[3:0]};
                            cnt_next = 2'd1;
                        end
                    end
                    else if (cnt_reg == 2'd0)
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_BODY;
                    end
                    else
                    begin
                        emit_a     = 1'b1;
                        phase_next = PH_BODY;
                        body_path  = 1'b1;
                    end
                end
                PH_OCT:
                begin
                    if (!fin && is_oct)
                    begin
                        if (cnt_reg == 2'd2)
                        begin
                            phase_next = PH_BODY;
                            if (oct_v[8])
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                emit_a = 1'b1;
                                byte_a = oct_v[7:0];
                            end
                        end
                        else
                        begin
                            val_next = oct_v[7:0];
                            cnt_next = 2'(cnt_reg + 2'd1);
                        end
                    end
                    else
                    begin
                        emit_a     = 1'b1;
                        phase_next = PH_BODY;
                        body_path  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_BODY;
                    body_path  = 1'b1;
                end
            endcase

            if (body_path && !fin)
            begin
                if (ch == csu_pkg::CH_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    emit_b = 1'b1;
                end
            end

            if (fin && ch != csu_pkg::CH_QUOTE)
            begin
                failed_next = 1'b1;
            end
        end

        res_a = '{out_byte: byte_a, byte_valid: 1'b1, run_end: 1'b0, status: 1'b0};
        res_b = '{out_byte: ch, byte_valid: 1'b1, run_end: 1'b0, status: 1'b0};
        res_e = '{out_byte: 8'd0, byte_valid: 1'b0, run_end: 1'b1, status: failed_next};

        // order: run byte, then body byte, then end result
        push.push0 = consume && (emit_a || emit_b || fin);
        push.push1 = consume && ((emit_a && emit_b) || ((emit_a || emit_b) && fin));
        push.res0  = emit_a ? res_a : (emit_b ? res_b : res_e);
        push.res1  = (emit_a && emit_b) ? res_b : res_e;

        // end of literal: back to the start
        if (fin)
        begin
            phase_next  = PH_OPEN;
            val_next    = 8'd0;
            cnt_next    = 2'd0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            val_reg    <= 8'd0;
            cnt_reg    <= 2'd0;
            failed_reg <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            val_reg    <= val_next;
            cnt_reg    <= cnt_next;
            failed_reg <= failed_next;
        end
    end

    a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && failed_reg && !fin) |-> !push.push0)
        else $error("decoded byte emitted after failure");

    a_end_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && fin) |-> ((push.push1 && push.res1.run_end)
                              || (!push.push1 && push.res0.run_end)))
        else $error("final item did not end with the end result");

    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && fin) |=> (phase_reg == PH_OPEN && !failed_reg))
        else $error("decoder not back at start after end of literal");

endmodule

`default_nettype wire

// ===== rtl/core/csu_out_fifo.sv =====
// Result buffer: takes up to two results a cycle, hands out one a cycle while out_ready is high.
`default_nettype none

module csu_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire csu_pkg::push_t push,
    output logic                room2,
    output logic                out_valid,
    input  wire logic           out_ready,
    output csu_pkg::res_t       head
);

    localparam int DEPTH = csu_pkg::RES_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    csu_pkg::res_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pop;
    logic [PW-1:0]  wr_plus1;

    assign room2     = (cnt_reg <= CW'(DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_reg];
    assign wr_plus1  = PW'(wr_reg + 1'b1);

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        if (push.push1)
        begin
            wr_next = PW'(wr_reg + 2'd2);
        end
        else if (push.push0)
        begin
            wr_next = wr_plus1;
        end
        if (pop)
        begin
            rd_next = PW'(rd_reg + 1'b1);
        end
        cnt_next = CW'(cnt_reg + CW'(push.push0) + CW'(push.push1) - CW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[wr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem_reg[wr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result buffer overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> room2)
        else $error("push without room for two results");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != CW'(DEPTH)) |-> (PW'(wr_reg - rd_reg) == PW'(cnt_reg)))
        else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== rtl/core/c_string_literal_unescape.sv =====
// Top level of the C string literal decoder: input register, decoder, result buffer.
//
// Decodes one double-quoted C string literal, one raw byte per item, the closing quote
// flagged with is_final. Each item yields zero, one or two results: decoded bytes
// (byte_valid=1) and, on the final item, an end result (run_end=1) whose status is 1
// when the literal was malformed; the consumer then discards that literal's bytes.
// An item is registered on acceptance and decoded from the input register once the result
// buffer has room for two results; its results are then written to the result buffer. The
// block takes one item per cycle while the output drains; the sustained rate is set by the
// output port, one result per cycle, so items that close a hex or octal run and yield two
// results cost an extra output slot, absorbed by the four-entry result buffer.
`default_nettype none

module c_string_literal_unescape (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_end,
    output logic            status
);

    logic           vld_reg, vld_next;
    logic [7:0]     ch_reg;
    logic           fin_reg;
    logic           room2;
    logic           consume;
    csu_pkg::push_t push;
    csu_pkg::res_t  head;

    assign consume  = vld_reg && room2;
    assign in_ready = !vld_reg || room2;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            fin_reg <= is_final;
        end
    end

    csu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .consume (consume),
        .ch      (ch_reg),
        .fin     (fin_reg),
        .push    (push)
    );

    csu_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte   = head.out_byte;
    assign byte_valid = head.byte_valid;
    assign run_end    = head.run_end;
    assign status     = head.status;

    a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_end) |-> (!byte_valid && out_byte == 8'd0))
        else $error("end result carries a byte");

    a_hold_unconsumed: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !consume) |=> (vld_reg && $stable(ch_reg) && $stable(fin_reg)))
        else $error("input register lost an item");

    a_ok_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_end) |-> !status)
        else $error("status set on a byte result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the C string literal decoder with a behavioral decode predictor.
module tb_top;

    typedef enum logic [2:0] {
        ST_QUOTE_WAIT,
        ST_TEXT,
        ST_ESCAPE,
        ST_HEX_RUN,
        ST_OCT_RUN
    } dec_state_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         gap;
        bit         drain;
    } raw_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       is_final = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       status;

    // decoder state as the predictor sees it
    dec_state_t  dec_state;
    int unsigned run_val;
    logic [1:0]  run_digits;
    bit          dec_failed;

    csu_pkg::res_t decoded_q[$];
    raw_item_t     raw_q[$];
    logic [7:0]    lit_buf[$];

    int  err_cnt = 0;
    int  items_taken = 0;
    int  results_seen = 0;
    int  literal_cnt = 0;
    int  lits_ok = 0;
    int  lits_bad = 0;
    int  idle_cnt = 0;
    int  stall_cnt = 0;
    int  stall_draw;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    c_string_literal_unescape uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .is_final   (is_final),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_end    (run_end),
        .status     (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d results still outstanding", decoded_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_decoder();
        dec_state  = ST_QUOTE_WAIT;
        run_val    = 0;
        run_digits = 2'd0;
        dec_failed = 1'b0;
    endfunction

    function automatic void expect_byte(input logic [7:0] b);
        csu_pkg::res_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.run_end    = 1'b0;
        r.status     = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function automatic void mark_failed();
        dec_failed = 1'b1;
        dec_state  = ST_TEXT;
    endfunction

    function automatic void text_byte(input logic [7:0] c);
        if (c == csu_pkg::CH_BACKSLASH)
            dec_state = ST_ESCAPE;
        else
            expect_byte(c);
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'(csu_pkg::CH_ZERO);
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic int esc_byte(input logic [7:0] c);
        case (c)
            "'":     return 8'h27;
            "\"":    return 8'h22;
            "?":     return 8'h3F;
            "\\":    return 8'h5C;
            "a":     return 7;
            "b":     return 8;
            "f":     return 12;
            "n":     return 10;
            "r":     return 13;
            "t":     return 9;
            "v":     return 11;
            default: return -1;
        endcase
    endfunction

    function automatic bit is_oct(input logic [7:0] c);
        return c >= csu_pkg::CH_ZERO && c <= csu_pkg::CH_SEVEN;
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic fin);
        int            d;
        int            s;
        int unsigned   v;
        csu_pkg::res_t r;
        if (!dec_failed)
        begin
            case (dec_state)
                ST_QUOTE_WAIT:
                begin
                    if (fin || c != csu_pkg::CH_QUOTE)
                        mark_failed();
                    else
                        dec_state = ST_TEXT;
                end
                ST_ESCAPE:
                begin
                    s = esc_byte(c);
                    if (fin)
                        mark_failed();
                    else if (s >= 0)
                    begin
                        expect_byte(s[7:0]);
                        dec_state = ST_TEXT;
                    end
                    else if (c == csu_pkg::CH_X)
                    begin
                        run_val    = 0;
                        run_digits = 2'd0;
                        dec_state  = ST_HEX_RUN;
                    end
                    else if (is_oct(c))
                    begin
                        run_val    = c - csu_pkg::CH_ZERO;
                        run_digits = 2'd1;
                        dec_state  = ST_OCT_RUN;
                    end
                    else
                        mark_failed();
                end
                ST_HEX_RUN:
                begin
                    d = fin ? -1 : hex_val(c);
                    if (d >= 0)
                    begin
                        v = run_val * 16 + d;
                        if (v > 255)
                            mark_failed();
                        else
                        begin
                            run_val    = v;
                            run_digits = 2'd1;
                        end
                    end
                    else if (run_digits == 2'd0)
                        mark_failed();
                    else
                    begin
                        // the byte that ends the run is then handled on its own
                        expect_byte(run_val[7:0]);
                        dec_state = ST_TEXT;
                        if (!fin)
                            text_byte(c);
                    end
                end
                ST_OCT_RUN:
                begin
                    if (!fin && is_oct(c))
                    begin
                        v = run_val * 8 + (c - csu_pkg::CH_ZERO);
                        run_digits = run_digits + 2'd1;
                        if (run_digits == 2'd3)
                        begin
                            if (v > 255)
                                mark_failed();
                            else
                            begin
                                expect_byte(v[7:0]);
                                dec_state = ST_TEXT;
                            end
                        end
                        else
                            run_val = v & 32'h1FF;
                    end
                    else
                    begin
                        expect_byte(run_val[7:0]);
                        dec_state = ST_TEXT;
                        if (!fin)
                            text_byte(c);
                    end
                end
                default:
                begin
                    dec_state = ST_TEXT;
                    if (!fin)
                        text_byte(c);
                end
            endcase
            if (fin && !dec_failed && c != csu_pkg::CH_QUOTE)
                dec_failed = 1'b1;
        end
        if (fin)
        begin
            r.out_byte   = 8'h00;
            r.byte_valid = 1'b0;
            r.run_end    = 1'b1;
            r.status     = dec_failed;
            decoded_q.push_back(r);
            if (dec_failed)
                lits_bad++;
            else
                lits_ok++;
            clear_decoder();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            lit_buf.push_back(s[i]);
    endfunction

    function automatic void emit_literal(input bit drain);
        raw_item_t it;
        foreach (lit_buf[i])
        begin
            if ($urandom_range(0, 31) == 0)
                tx_calm = !tx_calm;
            it.ch    = lit_buf[i];
            it.fin   = (i == lit_buf.size() - 1);
            it.gap   = tx_calm ? 0 : $urandom_range(0, 15);
            it.drain = drain && (i == 0);
            raw_q.push_back(it);
        end
        lit_buf.delete();
        literal_cnt++;
    endfunction

    function automatic logic [7:0] hex_char(input int d);
        string      digits = "0123456789abcdef";
        logic [7:0] c;
        c = digits[d];
        if (d >= 10 && $urandom_range(0, 1) == 1)
            c = c - 8'h20;
        return c;
    endfunction

    function automatic void add_hex_escape(input bit overflow);
        int unsigned v;
        int          nd;
        if (overflow)
        begin
            v  = $urandom_range(256, 4095);
            nd = 3;
        end
        else
        begin
            v  = $urandom_range(0, 255);
            nd = (v > 15) ? 2 : 1;
            if ($urandom_range(0, 3) == 0)
                nd = nd + $urandom_range(1, 2);
        end
        lit_buf.push_back(csu_pkg::CH_BACKSLASH);
        lit_buf.push_back(csu_pkg::CH_X);
        for (int i = nd - 1; i >= 0; i--)
            lit_buf.push_back(hex_char((v >> (4 * i)) & 15));
    endfunction

    function automatic void add_oct_escape(input bit overflow);
        int unsigned v;
        int          nd;
        if (overflow)
        begin
            v  = $urandom_range(256, 511);
            nd = 3;
        end
        else
        begin
            v  = $urandom_range(0, 255);
            nd = (v > 63) ? 3 : (v > 7) ? 2 : 1;
            if (nd < 3 && $urandom_range(0, 3) == 0)
                nd = 3;
        end
        lit_buf.push_back(csu_pkg::CH_BACKSLASH);
        for (int i = nd - 1; i >= 0; i--)
            lit_buf.push_back(csu_pkg::CH_ZERO + 8'((v >> (3 * i)) & 7));
    endfunction

    function automatic void add_element();
        string      letters = "'\"?\\abfnrtv";
        logic [7:0] c;
        case ($urandom_range(0, 6))
            4:
            begin
                lit_buf.push_back(csu_pkg::CH_BACKSLASH);
                lit_buf.push_back(letters[$urandom_range(0, 10)]);
            end
            5: add_hex_escape(1'b0);
            6: add_oct_escape(1'b0);
            default:
            begin
                c = 8'($urandom_range(0, 255));
                if (c == csu_pkg::CH_BACKSLASH || $urandom_range(0, 9) == 0)
                    c = csu_pkg::CH_QUOTE;
                lit_buf.push_back(c);
            end
        endcase
    endfunction

    function automatic void add_fault(input int kind);
        logic [7:0] c;
        case (kind)
            0:
            begin
                // escape letter outside the list
                do
                    c = 8'($urandom_range(0, 255));
                while (esc_byte(c) >= 0 || c == csu_pkg::CH_X || is_oct(c));
                lit_buf.push_back(csu_pkg::CH_BACKSLASH);
                lit_buf.push_back(c);
            end
            1: add_hex_escape(1'b1);
            2: add_oct_escape(1'b1);
            default:
            begin
                // hex escape with no digit
                do
                    c = 8'($urandom_range(0, 255));
                while (hex_val(c) >= 0);
                lit_buf.push_back(csu_pkg::CH_BACKSLASH);
                lit_buf.push_back(csu_pkg::CH_X);
                lit_buf.push_back(c);
            end
        endcase
    endfunction

    function automatic void build_literal();
        int         n_elem;
        int         fault;
        int         where;
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0)
        begin
            // unstructured noise
            n_elem = $urandom_range(1, 6);
            for (int i = 0; i < n_elem; i++)
            begin
                case ($urandom_range(0, 5))
                    0: c = csu_pkg::CH_QUOTE;
                    1: c = csu_pkg::CH_BACKSLASH;
                    2: c = csu_pkg::CH_X;
                    3: c = 8'($urandom_range(csu_pkg::CH_ZERO, csu_pkg::CH_SEVEN));
                    default: c = 8'($urandom_range(0, 255));
                endcase
                lit_buf.push_back(c);
            end
            return;
        end
        fault  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : -1;
        n_elem = $urandom_range(0, 6);
        where  = $urandom_range(0, n_elem);
        lit_buf.push_back(csu_pkg::CH_QUOTE);
        for (int i = 0; i <= n_elem; i++)
        begin
            if (i == where && fault >= 0 && fault <= 3)
                add_fault(fault);
            if (i < n_elem)
                add_element();
        end
        if (fault == 4)
            lit_buf.push_back(csu_pkg::CH_BACKSLASH);
        lit_buf.push_back(csu_pkg::CH_QUOTE);
        if (fault == 5)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == csu_pkg::CH_QUOTE);
            lit_buf[lit_buf.size() - 1] = c;
        end
        if (fault == 6)
            lit_buf[0] = 8'($urandom_range(0, 255))
                         ^ ((lit_buf[0] == csu_pkg::CH_QUOTE) ? 8'h01 : 8'h00);
        if (fault == 7)
        begin
            lit_buf.delete();
            lit_buf.push_back(csu_pkg::CH_QUOTE);
        end
    endfunction

    // ---------------------------------------------------------------- sender

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch       <= 8'h00;
            is_final <= 1'b0;
            idle_cnt <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(ch, is_final);
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (raw_q.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_cnt < raw_q[0].gap)
                begin
                    idle_cnt <= idle_cnt + 1;
                    in_valid <= 1'b0;
                end
                else if (raw_q[0].drain && decoded_q.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    ch       <= raw_q[0].ch;
                    is_final <= raw_q[0].fin;
                    idle_cnt <= 0;
                    void'(raw_q.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_result();
        csu_pkg::res_t want;
        if (decoded_q.size() == 0)
        begin
            flag_error($sformatf("unexpected result byte=%02h bv=%0b end=%0b st=%0b",
                                 out_byte, byte_valid, run_end, status));
            return;
        end
        want = decoded_q.pop_front();
        results_seen++;
        if (out_byte !== want.out_byte)
            flag_error($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
        if (byte_valid !== want.byte_valid)
            flag_error($sformatf("byte_valid %0b, want %0b", byte_valid, want.byte_valid));
        if (run_end !== want.run_end)
            flag_error($sformatf("run_end %0b, want %0b", run_end, want.run_end));
        if (status !== want.status)
            flag_error($sformatf("status %0b, want %0b", status, want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                stall_draw = rx_calm ? 0 : $urandom_range(0, 15);
                stall_cnt <= stall_draw;
                out_ready <= (stall_draw == 0);
            end
            else if (!out_ready)
            begin
                // hold off until the drawn stall runs out
                if (stall_cnt <= 1)
                    out_ready <= 1'b1;
                if (stall_cnt > 0)
                    stall_cnt <= stall_cnt - 1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        clear_decoder();

        // directed literals
        add_text("\"\"");
        emit_literal(1'b0);
        add_text("\"");
        emit_literal(1'b0);
        lit_buf.push_back(8'hFF);
        add_text("\"");
        emit_literal(1'b0);
        add_text("\"z");
        emit_literal(1'b0);
        add_text("\"\\\"");
        emit_literal(1'b0);
        add_text("\"\\q\"");
        emit_literal(1'b0);
        add_text("\"\\xg\"");
        emit_literal(1'b0);
        add_text("\"");
        lit_buf.push_back(8'h00);
        add_text("\"\\xfF\"");
        emit_literal(1'b0);

        // random literals, mostly well formed
        while (raw_q.size() < 820)
        begin
            build_literal();
            emit_literal(literal_cnt == 8 || $urandom_range(0, 39) == 0);
        end

        wait (rst_n);
        while (raw_q.size() != 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d literals as %0d bytes: %0d well formed, %0d malformed.",
                 literal_cnt, items_taken, lits_ok, lits_bad);
        $display("Checked %0d results, %0d mismatches.", results_seen, err_cnt);
        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
